>>> rtl/core/key_hash_destination_select_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key hash destination select block
// Shared helpers for writing clocked implications with reset disable.
// ----------------------------------------------------------------------------
`ifndef KEY_HASH_DESTINATION_SELECT_ASSERT_SVH
`define KEY_HASH_DESTINATION_SELECT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define KHDS_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define KHDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/khds_pkg.sv
// ----------------------------------------------------------------------------
// khds_pkg
// Constants, register codes and shared types of the key hash destination
// select block.
// ----------------------------------------------------------------------------
package khds_pkg;

  // Hash constants
  localparam logic [31:0] HashSeed  = 32'd5381;
  localparam logic [31:0] HashMul   = 32'h5bd1e995;
  localparam int unsigned ShiftMix  = 24;
  localparam int unsigned ShiftFin1 = 13;
  localparam int unsigned ShiftFin2 = 15;

  // Field widths
  localparam int unsigned HashW     = 32;
  localparam int unsigned BucketW   = 16;
  localparam int unsigned DestCntW  = 5;
  localparam int unsigned KeyLenW   = 16;
  localparam int unsigned NbytesW   = 3;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] RegBucketCount = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegDestCount   = CfgIdxW'(1);
  localparam logic [BucketW-1:0]  BucketCountRst = 16'd1024;
  localparam logic [DestCntW-1:0] DestCountRst   = 5'd1;

  // Defaults and sizes
  localparam int unsigned DefMaxDests = 16;
  localparam int unsigned QueueDepth  = 2;

  // Shared divider request and response
  typedef struct packed {
    logic               start;
    logic               long_op;   // 32-bit dividend, else 16-bit in the upper half
    logic [HashW-1:0]   dividend;
    logic [BucketW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [HashW-1:0]   quotient;
    logic [BucketW-1:0] remainder;
  } div_rsp_t;

  // Byte mask for a short final word
  function automatic logic [HashW-1:0] tail_mask(input logic [NbytesW-1:0] nb);
    logic [HashW-1:0] m;
    case (nb)
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = '1;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/core/khds_fifo.sv
// ----------------------------------------------------------------------------
// khds_fifo
// Short queue of unfinalized key hashes between the mixing front and the
// routing back end.
// ----------------------------------------------------------------------------
module khds_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [khds_pkg::HashW-1:0] data_i,
  input  logic                       pop_i,
  output logic [khds_pkg::HashW-1:0] data_o,
  output logic                       full_o,
  output logic                       empty_o
);

  localparam int unsigned Depth = khds_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [khds_pkg::HashW-1:0] mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/khds_div.sv
// ----------------------------------------------------------------------------
// khds_div
// Shared restoring divider, four quotient bits per cycle. Long operations
// take a 32-bit dividend, short ones a 16-bit dividend in the upper half.
// ----------------------------------------------------------------------------
module khds_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  khds_pkg::div_req_t req_i,
  output khds_pkg::div_rsp_t rsp_o
);

  localparam int unsigned DvdW       = khds_pkg::HashW;
  localparam int unsigned DsrW       = khds_pkg::BucketW;
  localparam int unsigned DigitBits  = 4;
  localparam int unsigned LongSteps  = DvdW / DigitBits;
  localparam int unsigned ShortSteps = DsrW / DigitBits;
  localparam int unsigned CntW       = $clog2(LongSteps + 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DvdW-1:0] dvd_q, dvd_n;
  logic [DsrW-1:0] rem_q, rem_n, dsr_q;
  logic [DsrW:0]   trial;

  // One digit: four shift-subtract steps
  always_comb begin
    rem_n = rem_q;
    dvd_n = dvd_q;
    trial = '0;
    for (int i = 0; i < DigitBits; i++) begin
      trial = {rem_n, dvd_n[DvdW-1]};
      dvd_n = {dvd_n[DvdW-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        trial    = trial - {1'b0, dsr_q};
        dvd_n[0] = 1'b1;
      end
      rem_n = trial[DsrW-1:0];
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      dvd_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      dvd_q <= dvd_n;
      rem_q <= rem_n;
    end
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.long_op ? CntW'(LongSteps) : CntW'(ShortSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dvd_q;
  assign rsp_o.remainder = rem_q;

endmodule

>>> rtl/core/khds_front.sv
// ----------------------------------------------------------------------------
// khds_front
// Accepts key words, mixes them into the running hash (product, then mix step)
// and pushes the unfinalized hash of each completed key into the queue.
// ----------------------------------------------------------------------------
module khds_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [khds_pkg::HashW-1:0]    key_word_i,
  input  logic [khds_pkg::NbytesW-1:0]  bytes_valid_i,
  input  logic                          first_word_i,
  input  logic                          last_word_i,
  input  logic [khds_pkg::KeyLenW-1:0]  key_length_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output logic [khds_pkg::HashW-1:0]    push_hash_o
);

  logic                       busy_q, last_q, full_q, none_q;
  logic [khds_pkg::HashW-1:0] hash_q, hstart_q, k1_q, hm_q;
  logic [khds_pkg::HashW-1:0] hstart, mul_op, kx, hnew;
  logic                       accept;

  assign in_ready_o = !busy_q && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Starting hash and the operand of the h multiply
  assign hstart = first_word_i ?
                  (khds_pkg::HashSeed ^ {16'd0, key_length_i}) : hash_q;
  assign mul_op = bytes_valid_i[2] ? hstart :
                  (hstart ^ (key_word_i & khds_pkg::tail_mask(bytes_valid_i)));

  // Product step: word and hash products
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hstart_q <= hstart;
      k1_q     <= key_word_i * khds_pkg::HashMul;
      hm_q     <= mul_op * khds_pkg::HashMul;
      full_q   <= bytes_valid_i[2];
      none_q   <= (bytes_valid_i == '0);
      last_q   <= last_word_i;
    end
  end

  // Mix step: finish the word mix
  assign kx   = k1_q ^ (k1_q >> khds_pkg::ShiftMix);
  assign hnew = full_q ? (hm_q ^ (kx * khds_pkg::HashMul)) :
                none_q ? hstart_q : hm_q;

  assign push_o      = busy_q && last_q;
  assign push_hash_o = hnew;

  // Running hash and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      hash_q <= '0;
    end else begin
      if (busy_q) begin
        hash_q <= hnew;
      end
      busy_q <= accept;
    end
  end

endmodule

>>> rtl/core/khds_back.sv
// ----------------------------------------------------------------------------
// khds_back
// Finalizes queued hashes, works out bucket and destination with the shared
// divider and holds the result in an output register.
// ----------------------------------------------------------------------------
module khds_back #(
  parameter int unsigned MAX_DESTS = khds_pkg::DefMaxDests,
  localparam int unsigned IdxW     = (MAX_DESTS > 1) ? $clog2(MAX_DESTS) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  logic [khds_pkg::HashW-1:0]     q_hash_i,
  output logic                           pop_o,
  input  logic [khds_pkg::BucketW-1:0]   bucket_count_i,
  input  logic [khds_pkg::DestCntW-1:0]  dest_count_i,
  output khds_pkg::div_req_t             div_req_o,
  input  khds_pkg::div_rsp_t             div_rsp_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [khds_pkg::HashW-1:0]     hash_value_o,
  output logic [khds_pkg::BucketW-1:0]   bucket_o,
  output logic [IdxW-1:0]                dest_index_o
);

  localparam int unsigned DcW     = khds_pkg::DestCntW;
  localparam int unsigned BkW     = khds_pkg::BucketW;
  localparam int unsigned DestSat = (MAX_DESTS < 31) ? MAX_DESTS : 31;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StFin1 = 3'd1;
  localparam logic [2:0] StFin2 = 3'd2;
  localparam logic [2:0] StPer  = 3'd3;
  localparam logic [2:0] StMod  = 3'd4;
  localparam logic [2:0] StIdx  = 3'd5;
  localparam logic [2:0] StDone = 3'd6;

  logic [2:0]                 state_q, state_d;
  logic [khds_pkg::HashW-1:0] h_q, p_q, hv_q;
  logic [BkW-1:0]             per_q, bkt_q, qsel;
  logic [IdxW-1:0]            idx_q;
  logic [DcW-1:0]             dests, dlim;
  logic [BkW-1:0]             dlim_w;
  logic                       out_valid_q, load_out;

  // Effective destination count and its last index
  assign dests  = (dest_count_i == '0) ? DcW'(1) :
                  (dest_count_i > DcW'(DestSat)) ? DcW'(DestSat) : dest_count_i;
  assign dlim   = dests - 1'b1;
  assign dlim_w = {{(BkW-DcW){1'b0}}, dlim};
  assign qsel   = (div_rsp_i.quotient[BkW-1:0] > dlim_w) ?
                  dlim_w : div_rsp_i.quotient[BkW-1:0];

  assign load_out = (state_q == StDone) && (!out_valid_q || out_ready_i);

  // Sequencer: next state, queue pop and divider requests
  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    div_req_o = '0;
    case (state_q)
      StIdle: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          state_d = StFin1;
        end
      end
      StFin1: state_d = StFin2;
      StFin2: begin
        if (bucket_count_i == '0) begin
          state_d = StDone;
        end else begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = {bucket_count_i, {BkW{1'b0}}};
          div_req_o.divisor  = {{(BkW-DcW){1'b0}}, dests};
          state_d            = StPer;
        end
      end
      StPer: begin
        if (div_rsp_i.done) begin
          div_req_o.start    = 1'b1;
          div_req_o.long_op  = 1'b1;
          div_req_o.dividend = hv_q;
          div_req_o.divisor  = bucket_count_i;
          state_d            = StMod;
        end
      end
      StMod: begin
        if (div_rsp_i.done) begin
          if (per_q == '0) begin
            state_d = StDone;
          end else begin
            div_req_o.start    = 1'b1;
            div_req_o.dividend = {div_rsp_i.remainder, {BkW{1'b0}}};
            div_req_o.divisor  = per_q;
            state_d            = StIdx;
          end
        end
      end
      StIdx: begin
        if (div_rsp_i.done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: h_q <= q_hash_i;
      StFin1: p_q <= (h_q ^ (h_q >> khds_pkg::ShiftFin1)) * khds_pkg::HashMul;
      StFin2: begin
        hv_q <= p_q ^ (p_q >> khds_pkg::ShiftFin2);
        if (bucket_count_i == '0) begin
          bkt_q <= '0;
          idx_q <= IdxW'(dlim);
        end
      end
      StPer: begin
        if (div_rsp_i.done) begin
          per_q <= div_rsp_i.quotient[BkW-1:0];
        end
      end
      StMod: begin
        if (div_rsp_i.done) begin
          bkt_q <= div_rsp_i.remainder;
          if (per_q == '0) begin
            idx_q <= IdxW'(dlim);
          end
        end
      end
      StIdx: begin
        if (div_rsp_i.done) begin
          idx_q <= IdxW'(qsel);
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      hash_value_o <= hv_q;
      bucket_o     <= bkt_q;
      dest_index_o <= idx_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/key_hash_destination_select.sv
// ----------------------------------------------------------------------------
// key_hash_destination_select
// MurmurHash2 (32-bit) of a streamed key, bucket and destination routing.
// ----------------------------------------------------------------------------
//
//   channel  signals                                   direction
//   -------  ----------------------------------------  ---------
//   in       in_valid_i/in_ready_o, key word fields    sink
//   out      out_valid_o/out_ready_i, hash/bucket/idx  source
//   cfg      cfg_valid_i/cfg_ready_o, index, data      sink
//
// Each key word passes the product and mix stages of the front mixer (the h
// multiply chain) before another is taken. Per key the back end pops, finalizes,
// divides on the shared 4-bit-per-cycle divider (per-dest size, bucket, index;
// none at zero bucket count, no index at zero per-dest size), loads the output.
// A 2-entry hash queue lets the front stream the next key; it stalls when full.
// Reset clears control state and the running hash and loads the configuration registers with their defaults.
// Configuration writes are always taken; the output holds while stalled.
//
module key_hash_destination_select #(
  parameter int unsigned MAX_DESTS = khds_pkg::DefMaxDests,
  localparam int unsigned IdxW     = (MAX_DESTS > 1) ? $clog2(MAX_DESTS) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Key word channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [khds_pkg::HashW-1:0]     key_word_i,
  input  logic [khds_pkg::NbytesW-1:0]   bytes_valid_i,
  input  logic                           first_word_i,
  input  logic                           last_word_i,
  input  logic [khds_pkg::KeyLenW-1:0]   key_length_i,
  // Result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [khds_pkg::HashW-1:0]     hash_value_o,
  output logic [khds_pkg::BucketW-1:0]   bucket_o,
  output logic [IdxW-1:0]                dest_index_o,
  // Configuration channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [khds_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [khds_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic [khds_pkg::BucketW-1:0]  bucket_count_q;
  logic [khds_pkg::DestCntW-1:0] dest_count_q;
  logic                          push, pop, q_full, q_empty;
  logic [khds_pkg::HashW-1:0]    push_hash, q_hash;
  khds_pkg::div_req_t            div_req;
  khds_pkg::div_rsp_t            div_rsp;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= khds_pkg::BucketCountRst;
      dest_count_q   <= khds_pkg::DestCountRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        khds_pkg::RegBucketCount: bucket_count_q <= cfg_data_i;
        khds_pkg::RegDestCount:   dest_count_q   <= cfg_data_i[khds_pkg::DestCntW-1:0];
        default: ;
      endcase
    end
  end

  // Word mixer
  khds_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .key_word_i    (key_word_i),
    .bytes_valid_i (bytes_valid_i),
    .first_word_i  (first_word_i),
    .last_word_i   (last_word_i),
    .key_length_i  (key_length_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_hash_o   (push_hash)
  );

  // Hash queue
  khds_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_hash),
    .pop_i   (pop),
    .data_o  (q_hash),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Shared divider
  khds_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Finalize and route
  khds_back #(
    .MAX_DESTS (MAX_DESTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_hash_i       (q_hash),
    .pop_o          (pop),
    .bucket_count_i (bucket_count_q),
    .dest_count_i   (dest_count_q),
    .div_req_o      (div_req),
    .div_rsp_i      (div_rsp),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hash_value_o   (hash_value_o),
    .bucket_o       (bucket_o),
    .dest_index_o   (dest_index_o)
  );

endmodule

>>> rtl/core/khds_checker.sv
// ----------------------------------------------------------------------------
// khds_checker
// Port-level checks of the key hash destination select block, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "key_hash_destination_select_assert.svh"

module khds_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [khds_pkg::HashW-1:0]    hash_value_o,
  input logic [khds_pkg::BucketW-1:0]  bucket_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [khds_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [khds_pkg::CfgDataW-1:0] cfg_data_i
);

  logic [khds_pkg::BucketW-1:0] bc_q;

  // Mirror of the bucket count register as seen on the port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q <= khds_pkg::BucketCountRst;
    end else if (cfg_valid_i && cfg_ready_o && cfg_index_i == khds_pkg::RegBucketCount) begin
      bc_q <= cfg_data_i;
    end
  end

  // A stalled result holds
  `KHDS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(hash_value_o) && $stable(bucket_o), "result changed while stalled")

  // No key word is accepted back-to-back with another
  `KHDS_ASSERT_NEXT(a_word_two_cycles, clk_i, rst_ni, in_valid_i && in_ready_o,
    !in_ready_o, "key word accepted on back-to-back cycles")

  // Bucket lies below the bucket count, or is zero when the count is zero
  `KHDS_ASSERT_IMPLIES(a_bucket_range, clk_i, rst_ni, out_valid_o,
    (bucket_o < bc_q) || (bc_q == '0 && bucket_o == '0), "bucket out of range")

  // Configuration writes are never back-pressured
  `KHDS_ASSERT_IMPLIES(a_cfg_ready, clk_i, rst_ni, cfg_valid_i,
    cfg_ready_o, "configuration transfer stalled")

endmodule

bind key_hash_destination_select khds_checker u_khds_checker (.*);
